/* rtl/bda_pkg.sv */
// Shared types and constants for the button debounce and auto-repeat block.
// Used by bda_div, bda_lane, button_debounce_autorepeat_unit and bda_checker.
package bda_pkg;

	// button slots: ten real buttons plus the aggregate flag
	localparam int BUTTON_SLOTS = 11;
	localparam int NUM_BUTTONS  = BUTTON_SLOTS - 1;
	localparam int FLAG_W       = BUTTON_SLOTS;

	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int RATE_W     = 10;
	localparam int OP_W       = 2;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// repeat interval is MS_PER_SEC / rate, computed one quotient bit a cycle
	localparam logic [RATE_W-1:0] MS_PER_SEC = RATE_W'(1000);
	localparam int DIV_STEPS = RATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MS_W-1:0] DEBOUNCE_RESET = MS_W'(10);

	typedef enum logic [OP_W-1:0] {
		OP_POLL = 2'd0,
		OP_READ = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_PRESENT_MASK = 3'd1,
		REG_REPEAT_MASK  = 3'd2,
		REG_REPEAT_RATE  = 3'd3,
		REG_REPEAT_DELAY = 3'd4
	} reg_idx_t;

	// timing settings shared by every button lane
	typedef struct packed {
		logic [MS_W-1:0]   debounce;
		logic [MS_W-1:0]   delay;
		logic [RATE_W-1:0] interval;
	} lane_cfg_t;

	// what one lane reports for the poll in the input stage
	typedef struct packed {
		logic event_hit;
		logic pressed;
	} lane_stat_t;

endpackage

/* rtl/bda_div.sv */
// Iterative restoring divider producing the repeat interval MS_PER_SEC / rate.
// Depends on bda_pkg.
module bda_div
	import bda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RATE_W-1:0] divisor,
	output logic              busy,
	output logic [RATE_W-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    quo_q;
	logic [RATE_W-1:0]    div_q;
	logic [RATE_W:0]      rem_shift;
	logic                 fits;
	logic [RATE_W:0]      rem_diff;

	// one quotient bit per cycle, dividend bits taken MSB first
	assign rem_shift = {rem_q, MS_PER_SEC[cnt_q]};
	assign fits      = rem_shift >= {1'b0, div_q};
	assign rem_diff  = rem_shift - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			// a zero rate gives a zero interval straight away
			busy_q <= divisor != '0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			quo_q  <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[RATE_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[RATE_W-1:0] : rem_shift[RATE_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/bda_lane.sv */
// One button lane: debounce window, level change and repeat scheduling.
// Holds the last event time and next repeat time. Depends on bda_pkg.
module bda_lane
	import bda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic [TIME_W-1:0] now,
	input  logic              pin_level,
	input  logic              held,
	input  logic              present,
	input  logic              rpt_en,
	input  lane_cfg_t         cfg,
	output lane_stat_t        stat
);

	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] next_q;
	logic [TIME_W-1:0] since_last;
	logic              open_win;
	logic              pressed;
	logic              due;
	logic              hit;
	logic [TIME_W-1:0] next_n;

	// debounce window measured modulo 2^32
	assign since_last = now - last_q;
	assign open_win   = present && (since_last >= {{(TIME_W-MS_W){1'b0}}, cfg.debounce});
	assign pressed    = ~pin_level;
	assign due        = (next_q != '0) && (now >= next_q);
	assign hit        = open_win && ((pressed != held) || due);

	// repeat schedule: arm on first hold, step on each due repeat, drop on release
	always_comb begin
		next_n = next_q;
		if (pressed) begin
			if (rpt_en) begin
				if (next_q == '0)
					next_n = now + {{(TIME_W-MS_W){1'b0}}, cfg.delay};
				else if (due)
					next_n = next_q + {{(TIME_W-RATE_W){1'b0}}, cfg.interval};
			end
		end else begin
			next_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			next_q <= '0;
		end else if (commit && open_win) begin
			next_q <= next_n;
			if (hit)
				last_q <= now;
		end
	end

	assign stat.event_hit = hit;
	assign stat.pressed   = pressed;

endmodule

/* rtl/button_debounce_autorepeat_unit.sv */
// Top level of the button debounce and auto-repeat block.
// Depends on bda_pkg, bda_div and bda_lane.
//
// Usage:
//  Input channel (in_valid / in_stall) carries one transaction per item:
//  operation, now_ms and pin_levels. Poll samples the pins (low = pressed),
//  read returns the flags and clears the just-pressed/released flags,
//  peek returns the flags untouched.
//  Output channel (out_valid / out_stall) returns one transaction per item:
//  held, just-pressed and just-released masks (bit 10 = aggregate flag) and the
//  per-button event mask of a poll.
//  Each item passes the input register, then the result register. One item is
//  taken every cycle while in_stall is low; all ten lanes update in parallel
//  from flip-flops. When the receiver stalls, the result register holds and
//  one further item waits in the input register; in_stall rises only when both
//  are full or while a divide runs. Writing a non-zero repeat rate starts a
//  bit-serial divide for the repeat interval; in_stall stays high while it runs.
//  Configuration is a plain write port (cfg_write, cfg_index, cfg_data).
//  Reset clears all flags, event and repeat times, and loads the register
//  defaults (debounce 10 ms, all buttons present, repeat off).
module button_debounce_autorepeat_unit
	import bda_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_write,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OP_W-1:0]        operation,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic [NUM_BUTTONS-1:0] pin_levels,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [FLAG_W-1:0]      held_mask,
	output logic [FLAG_W-1:0]      just_pressed_mask,
	output logic [FLAG_W-1:0]      just_released_mask,
	output logic [NUM_BUTTONS-1:0] event_mask
);

	// configuration registers
	logic [MS_W-1:0]        debounce_q;
	logic [NUM_BUTTONS-1:0] present_q;
	logic [NUM_BUTTONS-1:0] rpt_mask_q;
	logic [RATE_W-1:0]      rate_q;
	logic [MS_W-1:0]        delay_q;

	// flags
	logic [FLAG_W-1:0] held_q;
	logic [FLAG_W-1:0] jp_q;
	logic [FLAG_W-1:0] jr_q;

	// input stage
	logic                   valid_s1;
	logic [OP_W-1:0]        op_s1;
	logic [TIME_W-1:0]      now_s1;
	logic [NUM_BUTTONS-1:0] pins_s1;

	// result stage
	logic                   valid_s2;
	logic [FLAG_W-1:0]      held_s2;
	logic [FLAG_W-1:0]      jp_s2;
	logic [FLAG_W-1:0]      jr_s2;
	logic [NUM_BUTTONS-1:0] evt_s2;

	logic                   div_busy;
	logic [RATE_W-1:0]      interval;
	logic                   div_start;
	logic                   accept;
	logic                   advance;
	logic                   is_poll;
	logic                   is_read;
	logic                   rpt_global;
	lane_cfg_t              lane_cfg;
	lane_stat_t             stat [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] hit;
	logic [NUM_BUTTONS-1:0] prs;
	logic [FLAG_W-1:0]      held_n;
	logic [FLAG_W-1:0]      jp_n;
	logic [FLAG_W-1:0]      jr_n;
	logic                   agg_held;

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = div_busy || (valid_s1 && !advance);
	assign accept   = in_valid && !in_stall;
	assign is_poll  = op_s1 == OP_POLL;
	assign is_read  = op_s1 == OP_READ;

	// configuration decode
	assign div_start = cfg_write && (cfg_index == REG_REPEAT_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			present_q  <= '1;
			rpt_mask_q <= '0;
			rate_q     <= '0;
			delay_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q <= cfg_data[MS_W-1:0];
				REG_PRESENT_MASK: present_q  <= cfg_data[NUM_BUTTONS-1:0];
				REG_REPEAT_MASK:  rpt_mask_q <= cfg_data[NUM_BUTTONS-1:0];
				REG_REPEAT_RATE:  rate_q     <= cfg_data[RATE_W-1:0];
				REG_REPEAT_DELAY: delay_q    <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// repeat interval divider
	bda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (cfg_data[RATE_W-1:0]),
		.busy     (div_busy),
		.quotient (interval)
	);

	// button lanes
	assign rpt_global        = (rate_q != '0) && (delay_q != '0);
	assign lane_cfg.debounce = debounce_q;
	assign lane_cfg.delay    = delay_q;
	assign lane_cfg.interval = interval;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bda_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.commit    (advance && is_poll),
			.now       (now_s1),
			.pin_level (pins_s1[i]),
			.held      (held_q[i]),
			.present   (present_q[i]),
			.rpt_en    (rpt_mask_q[i] && rpt_global),
			.cfg       (lane_cfg),
			.stat      (stat[i])
		);
		assign hit[i] = stat[i].event_hit;
		assign prs[i] = stat[i].pressed;
	end

	// flag update for a poll; the last button with an event sets the aggregate level
	always_comb begin
		agg_held = held_q[NUM_BUTTONS];
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (hit[i])
				agg_held = prs[i];
		end
		held_n = {agg_held, (hit & prs) | (~hit & held_q[NUM_BUTTONS-1:0])};
		jp_n   = {jp_q[NUM_BUTTONS] | (|(hit & prs)),
			(hit & prs) | (~hit & jp_q[NUM_BUTTONS-1:0])};
		jr_n   = {jr_q[NUM_BUTTONS] | (|(hit & ~prs)),
			(hit & ~prs) | (~hit & jr_q[NUM_BUTTONS-1:0])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			jp_q   <= '0;
			jr_q   <= '0;
		end else if (advance) begin
			if (is_poll) begin
				held_q <= held_n;
				jp_q   <= jp_n;
				jr_q   <= jr_n;
			end else if (is_read) begin
				jp_q <= '0;
				jr_q <= '0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			now_s1  <= now_ms;
			pins_s1 <= pin_levels;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_s2 <= is_poll ? held_n : held_q;
			jp_s2   <= is_poll ? jp_n : jp_q;
			jr_s2   <= is_poll ? jr_n : jr_q;
			evt_s2  <= is_poll ? hit : '0;
		end
	end

	assign out_valid          = valid_s2;
	assign held_mask          = held_s2;
	assign just_pressed_mask  = jp_s2;
	assign just_released_mask = jr_s2;
	assign event_mask         = evt_s2;

endmodule

/* rtl/bda_checker.sv */
// Port-level checks for button_debounce_autorepeat_unit, bound to the top level.
// Depends on bda_pkg.
module bda_checker
	import bda_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_write,
	input logic [REG_IDX_W-1:0]   cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [FLAG_W-1:0]      held_mask,
	input logic [FLAG_W-1:0]      just_pressed_mask,
	input logic [FLAG_W-1:0]      just_released_mask,
	input logic [NUM_BUTTONS-1:0] event_mask
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(held_mask)
			&& $stable(event_mask))
		else $error("stalled result changed");

	// a button with an event shows matching held and just flags
	a_event_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((((just_pressed_mask[NUM_BUTTONS-1:0] ^ held_mask[NUM_BUTTONS-1:0])
			| (just_released_mask[NUM_BUTTONS-1:0] ~^ held_mask[NUM_BUTTONS-1:0]))
			& event_mask) == '0))
		else $error("event flags inconsistent");

	// any event leaves a mark in an aggregate just flag
	a_event_agg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_mask != '0) |->
			just_pressed_mask[NUM_BUTTONS] || just_released_mask[NUM_BUTTONS])
		else $error("aggregate flag missing");

	// a result appears only for a transaction taken at the input and passed through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without input");

	// a non-zero rate write holds off input while the interval is computed
	a_rate_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && (cfg_index == REG_REPEAT_RATE) && (cfg_data[RATE_W-1:0] != '0)
			|=> in_stall)
		else $error("input taken during interval divide");

endmodule

bind button_debounce_autorepeat_unit bda_checker u_bda_checker (.*);
